/* design/iba_pkg.sv */
// ----------------------------------------------------------------------------
// iba_pkg
// Shared operation codes, control struct and width helpers for the integer ALU.
// ----------------------------------------------------------------------------
package iba_pkg;

    localparam logic [3:0] OP_ABS     = 4'd0;
    localparam logic [3:0] OP_ABSDIFF = 4'd1;
    localparam logic [3:0] OP_ADDSAT  = 4'd2;
    localparam logic [3:0] OP_HADD    = 4'd3;
    localparam logic [3:0] OP_RHADD   = 4'd4;
    localparam logic [3:0] OP_MADHI   = 4'd5;
    localparam logic [3:0] OP_MADSAT  = 4'd6;
    localparam logic [3:0] OP_MULHI   = 4'd7;
    localparam logic [3:0] OP_SUBSAT  = 4'd8;
    localparam logic [3:0] OP_MAX     = 4'd9;
    localparam logic [3:0] OP_MIN     = 4'd10;
    localparam logic [3:0] OP_CLZ     = 4'd11;
    localparam logic [3:0] OP_CTZ     = 4'd12;
    localparam logic [3:0] OP_ROTATE  = 4'd13;
    localparam logic [3:0] OP_POPCNT  = 4'd14;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] wc;
        logic       s;
    } t_ctl;

    function automatic logic [63:0] wmask(input logic [1:0] wc);
        logic [63:0] m;
        case (wc)
            WC_8:    m = 64'h0000_0000_0000_00ff;
            WC_16:   m = 64'h0000_0000_0000_ffff;
            WC_32:   m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    // extend to 66 bits, two's complement
    function automatic logic signed [65:0] ext(input logic [63:0] x, input logic [1:0] wc,
                                               input logic s);
        logic signed [65:0] r;
        case (wc)
            WC_8:    r = {{58{s & x[7]}}, x[7:0]};
            WC_16:   r = {{50{s & x[15]}}, x[15:0]};
            WC_32:   r = {{34{s & x[31]}}, x[31:0]};
            default: r = {{2{s & x[63]}}, x};
        endcase
        return r;
    endfunction

    function automatic logic [63:0] clamp(input logic signed [130:0] v, input logic [1:0] wc,
                                          input logic s);
        logic signed [130:0] lo;
        logic signed [130:0] hi;
        logic signed [130:0] r;
        logic [6:0]          w;
        w = 7'd8 << wc;
        if (s) begin
            hi = (131'sd1 <<< (w - 7'd1)) - 131'sd1;
            lo = -hi - 131'sd1;
        end else begin
            hi = (131'sd1 <<< w) - 131'sd1;
            lo = '0;
        end
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r[63:0] & wmask(wc);
    endfunction

endpackage

/* design/iba_simple.sv */
// ----------------------------------------------------------------------------
// iba_simple
// Single-stage logic for every operation that needs no product.
// ----------------------------------------------------------------------------
module iba_simple (
    input  iba_pkg::t_ctl       i_ctl,
    input  logic signed [65:0]  i_ea,
    input  logic signed [65:0]  i_eb,
    input  logic [63:0]         i_ua,
    output logic [63:0]         o_value
);

    logic signed [130:0] sum;
    logic signed [130:0] dif;
    logic signed [130:0] rsum;
    logic signed [130:0] tmp;
    logic [63:0]         mask;
    logic [6:0]          lz;
    logic [6:0]          tz;
    logic [6:0]          w;
    logic [5:0]          n;
    logic [15:0]         d8;
    logic [31:0]         d16;
    logic [63:0]         d32;
    logic [127:0]        d64;
    logic [63:0]         rot;

    always_comb begin
        mask = iba_pkg::wmask(i_ctl.wc);
        w    = 7'd8 << i_ctl.wc;
        sum  = 131'(i_ea) + 131'(i_eb);
        dif  = 131'(i_ea) - 131'(i_eb);
        rsum = sum + 131'sd1;
        lz = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (i_ua[i]) lz = 7'(63 - i);
        end
        tz = 7'd64;
        for (int i = 63; i >= 0; i--) begin
            if (i_ua[i]) tz = 7'(i);
        end
        n   = i_eb[5:0] & 6'(w - 7'd1);
        d8  = {i_ua[7:0], i_ua[7:0]} << n[2:0];
        d16 = {i_ua[15:0], i_ua[15:0]} << n[3:0];
        d32 = {i_ua[31:0], i_ua[31:0]} << n[4:0];
        d64 = {i_ua, i_ua} << n;
        case (i_ctl.wc)
            iba_pkg::WC_8:  rot = {56'd0, d8[15:8]};
            iba_pkg::WC_16: rot = {48'd0, d16[31:16]};
            iba_pkg::WC_32: rot = {32'd0, d32[63:32]};
            default:        rot = d64[127:64];
        endcase
        tmp = '0;
        unique case (i_ctl.mode)
            iba_pkg::OP_ABS: begin
                tmp     = 131'(i_ea);
                o_value = (tmp[130] ? 64'(-tmp) : tmp[63:0]) & mask;
            end
            iba_pkg::OP_ABSDIFF: o_value = (dif[130] ? 64'(-dif) : dif[63:0]) & mask;
            iba_pkg::OP_ADDSAT:  o_value = iba_pkg::clamp(sum, i_ctl.wc, i_ctl.s);
            iba_pkg::OP_SUBSAT:  o_value = iba_pkg::clamp(dif, i_ctl.wc, i_ctl.s);
            iba_pkg::OP_HADD: begin
                tmp     = sum >>> 1;
                o_value = tmp[63:0] & mask;
            end
            iba_pkg::OP_RHADD: begin
                tmp     = rsum >>> 1;
                o_value = tmp[63:0] & mask;
            end
            iba_pkg::OP_MAX:    o_value = ((i_ea < i_eb) ? i_eb[63:0] : i_ea[63:0]) & mask;
            iba_pkg::OP_MIN:    o_value = ((i_eb < i_ea) ? i_eb[63:0] : i_ea[63:0]) & mask;
            iba_pkg::OP_CLZ:    o_value = {57'd0, lz - (7'd64 - w)};
            iba_pkg::OP_CTZ:    o_value = {57'd0, (tz > w) ? w : tz};
            iba_pkg::OP_ROTATE: o_value = rot;
            iba_pkg::OP_POPCNT: o_value = {57'd0, 7'($countones(i_ua))};
            default:            o_value = '0;
        endcase
    end

endmodule

/* design/iba_mul.sv */
// ----------------------------------------------------------------------------
// iba_mul
// Three-stage signed multiplier with addend: 32x32 partial products, product
// sum, then sign apply and addend.
// ----------------------------------------------------------------------------
module iba_mul (
    input  logic                 i_clk,
    input  logic signed [65:0]   i_ea,
    input  logic signed [65:0]   i_eb,
    input  logic signed [65:0]   i_ec,
    output logic signed [128:0]  o_prod,
    output logic signed [130:0]  o_madd
);

    logic [65:0]  ma;
    logic [65:0]  mb;
    logic [63:0]  r_pp00, r_pp01, r_pp10, r_pp11;
    logic         r_neg2, r_neg3;
    logic signed [65:0] r_c2, r_c3;
    logic [127:0] r_u;
    logic signed [128:0] r_p;
    logic signed [130:0] r_t;

    always_comb begin
        ma = i_ea[65] ? 66'(-i_ea) : i_ea;
        mb = i_eb[65] ? 66'(-i_eb) : i_eb;
    end

    always_ff @(posedge i_clk) begin
        r_pp00 <= 64'(ma[31:0])  * 64'(mb[31:0]);
        r_pp01 <= 64'(ma[31:0])  * 64'(mb[63:32]);
        r_pp10 <= 64'(ma[63:32]) * 64'(mb[31:0]);
        r_pp11 <= 64'(ma[63:32]) * 64'(mb[63:32]);
        r_neg2 <= i_ea[65] ^ i_eb[65];
        r_c2   <= i_ec;
        r_u    <= {64'd0, r_pp00} + {32'd0, r_pp01, 32'd0} + {32'd0, r_pp10, 32'd0}
                  + {r_pp11, 64'd0};
        r_neg3 <= r_neg2;
        r_c3   <= r_c2;
        r_p    <= r_neg3 ? -$signed({1'b0, r_u}) : $signed({1'b0, r_u});
        r_t    <= r_neg3 ? 131'(r_c3) - 131'({3'd0, r_u}) : 131'(r_c3) + 131'({3'd0, r_u});
    end

    assign o_prod = r_p;
    assign o_madd = r_t;

endmodule

/* design/integer_builtin_alu.sv */
// ----------------------------------------------------------------------------
// integer_builtin_alu
// Pipelined integer builtin ALU for 8/16/32/64-bit elements.
//
//   channel | handshake       | beat
//   --------+-----------------+-----------------------------------------------
//   input   | start & !busy   | i_mode i_width_code i_is_signed i_operand_a/b/c
//   result  | o_valid strobe  | o_result_value
//
// One beat per cycle in, one per cycle out; a beat passes through the input
// register, the three multiplier stages and the output register.
// busy is always low. Synchronous active-low reset clears the valid bits.
// ----------------------------------------------------------------------------
module integer_builtin_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_mode,
    input  logic [1:0]  i_width_code,
    input  logic        i_is_signed,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [63:0] i_operand_c,
    output logic        o_valid,
    output logic [63:0] o_result_value
);

    iba_pkg::t_ctl       r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [4:0]          r_v;
    logic signed [65:0]  r_ea, r_eb, r_ec;
    logic [63:0]         r_ua;
    logic [63:0]         r_c2, r_c3, r_c4;
    logic [63:0]         simple;
    logic [63:0]         r_s2, r_s3, r_s4;
    logic signed [128:0] prod;
    logic signed [130:0] madd;
    logic signed [128:0] sh;
    logic [63:0]         hi;
    logic [63:0]         mask;
    logic [63:0]         n_res;
    logic [63:0]         r_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl1 <= '{mode: i_mode, wc: i_width_code, s: i_is_signed};
        r_ea   <= iba_pkg::ext(i_operand_a, i_width_code, i_is_signed);
        r_eb   <= iba_pkg::ext(i_operand_b, i_width_code, i_is_signed);
        r_ec   <= iba_pkg::ext(i_operand_c, i_width_code, i_is_signed);
        r_ua   <= i_operand_a & iba_pkg::wmask(i_width_code);
        r_ctl2 <= r_ctl1;
        r_ctl3 <= r_ctl2;
        r_ctl4 <= r_ctl3;
        r_c2   <= r_ec[63:0];
        r_c3   <= r_c2;
        r_c4   <= r_c3;
        r_s2   <= simple;
        r_s3   <= r_s2;
        r_s4   <= r_s3;
        r_res  <= n_res;
    end

    iba_simple u_simple (
        .i_ctl   (r_ctl1),
        .i_ea    (r_ea),
        .i_eb    (r_eb),
        .i_ua    (r_ua),
        .o_value (simple)
    );

    iba_mul u_mul (
        .i_clk  (i_clk),
        .i_ea   (r_ea),
        .i_eb   (r_eb),
        .i_ec   (r_ec),
        .o_prod (prod),
        .o_madd (madd)
    );

    always_comb begin
        mask = iba_pkg::wmask(r_ctl4.wc);
        case (r_ctl4.wc)
            iba_pkg::WC_8:  sh = prod >>> 8;
            iba_pkg::WC_16: sh = prod >>> 16;
            iba_pkg::WC_32: sh = prod >>> 32;
            default:        sh = prod >>> 64;
        endcase
        hi = sh[63:0];
        case (r_ctl4.mode)
            iba_pkg::OP_MULHI:  n_res = hi & mask;
            iba_pkg::OP_MADHI:  n_res = (hi + r_c4) & mask;
            iba_pkg::OP_MADSAT: n_res = iba_pkg::clamp(madd, r_ctl4.wc, r_ctl4.s);
            default:            n_res = r_s4;
        endcase
    end

    assign o_valid        = r_v[4];
    assign o_result_value = r_res;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_valid)
        else $error("accepted beat did not appear after 5 cycles");
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##5 !o_valid)
        else $error("result strobe without accepted beat");
    a_width_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |=> ((o_result_value & ~iba_pkg::wmask($past(r_ctl4.wc))) == 64'd0))
        else $error("result has bits above element width");
`endif

endmodule
